[rtl/tagged_feedback_frame_parser_core_macros.svh]
// assertion macros for the tagged feedback frame parser
// used by the top level only, no other dependencies
`ifndef TAGGED_FEEDBACK_FRAME_PARSER_CORE_MACROS_SVH
`define TAGGED_FEEDBACK_FRAME_PARSER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define TFFP_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define TFFP_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

[rtl/tffp_pkg.sv]
// shared types and constants for the tagged feedback frame parser
// no dependencies
`timescale 1ns / 1ps

package tffp_pkg;

  // default last frame position, the end mark sits here
  localparam int LAST_POS_DEF = 25;

  // apb port geometry
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // fixed protocol bytes
  localparam logic [7:0] SEP_CHAR = 8'h3B;
  localparam logic [7:0] CR_CHAR  = 8'h0D;
  localparam logic [7:0] LF_CHAR  = 8'h0A;

  // configuration register reset values
  localparam logic [7:0] HEADER_RST = 8'd42;
  localparam logic [7:0] START_RST  = 8'd84;
  localparam logic [7:0] END_RST    = 8'd35;
  localparam logic [7:0] LEFT_RST   = 8'd76;
  localparam logic [7:0] RIGHT_RST  = 8'd82;
  localparam logic [7:0] MIDDLE_RST = 8'd90;

  // register index in the address map
  typedef enum logic [2:0] {
    REG_HEADER = 3'd0,
    REG_START  = 3'd1,
    REG_END    = 3'd2,
    REG_LEFT   = 3'd3,
    REG_RIGHT  = 3'd4,
    REG_MIDDLE = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] header_char;
    logic [7:0] start_char;
    logic [7:0] end_char;
    logic [7:0] left_tag;
    logic [7:0] right_tag;
    logic [7:0] middle_tag;
  } cfg_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_RECV,
    S_SCAN,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic start_frame;
    logic shift_in;
    logic scan_step;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_hit;
    logic end_hit;
    logic stop_hit;
  } status_t;

endpackage

[rtl/tffp_regs.sv]
// apb configuration registers for the frame parser
// depends on tffp_pkg
`timescale 1ns / 1ps

module tffp_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tffp_pkg::ADDR_W-1:0] paddr,
  input  logic [tffp_pkg::DATA_W-1:0] pwdata,
  output logic [tffp_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tffp_pkg::cfg_t             cfg
);
  import tffp_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;
  logic [7:0] rd_byte;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_char <= HEADER_RST;
      cfg.start_char  <= START_RST;
      cfg.end_char    <= END_RST;
      cfg.left_tag    <= LEFT_RST;
      cfg.right_tag   <= RIGHT_RST;
      cfg.middle_tag  <= MIDDLE_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HEADER: cfg.header_char <= pwdata[7:0];
        REG_START:  cfg.start_char  <= pwdata[7:0];
        REG_END:    cfg.end_char    <= pwdata[7:0];
        REG_LEFT:   cfg.left_tag    <= pwdata[7:0];
        REG_RIGHT:  cfg.right_tag   <= pwdata[7:0];
        REG_MIDDLE: cfg.middle_tag  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_HEADER: rd_byte = cfg.header_char;
      REG_START:  rd_byte = cfg.start_char;
      REG_END:    rd_byte = cfg.end_char;
      REG_LEFT:   rd_byte = cfg.left_tag;
      REG_RIGHT:  rd_byte = cfg.right_tag;
      REG_MIDDLE: rd_byte = cfg.middle_tag;
      default:    rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(DATA_W-8){1'b0}}, rd_byte};

endmodule

[rtl/tffp_ctrl.sv]
// controller state machine: framing, position count, scan sequencing
// depends on tffp_pkg
`timescale 1ns / 1ps

module tffp_ctrl #(
  parameter int LAST_POS = tffp_pkg::LAST_POS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  tffp_pkg::status_t  status,
  output tffp_pkg::cmd_t     cmd
);
  import tffp_pkg::*;

  localparam int PW = $clog2(LAST_POS + 1);
  localparam int SW = $clog2(LAST_POS);

  state_t        state, state_next;
  logic [PW-1:0] pos, pos_next;
  logic [SW-1:0] scan_idx, scan_idx_next;
  logic          out_valid_next;
  logic          slot_free;
  logic          frame_full;
  logic          scan_last;

  assign slot_free  = !out_valid || !out_stall;
  assign frame_full = (pos == PW'(LAST_POS - 1));
  assign scan_last  = status.stop_hit || (scan_idx == SW'(LAST_POS - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && status.start_hit) state_next = S_RECV;
      end
      S_RECV: begin
        if (in_valid && frame_full) begin
          state_next = status.end_hit ? S_SCAN : S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_stall        = !((state == S_IDLE) || (state == S_RECV));
    cmd.accept      = in_valid && !in_stall;
    cmd.start_frame = (state == S_IDLE) && cmd.accept && status.start_hit;
    cmd.shift_in    = (state == S_RECV) && cmd.accept;
    cmd.scan_step   = (state == S_SCAN);
    cmd.load_out    = (state == S_DONE) && slot_free;
  end

  // counters and result flag
  always_comb begin
    pos_next       = pos;
    scan_idx_next  = scan_idx;
    out_valid_next = out_valid && out_stall;
    if (cmd.start_frame) pos_next = PW'(1);
    else if (cmd.shift_in) pos_next = pos + PW'(1);
    if (cmd.scan_step) scan_idx_next = scan_idx + SW'(1);
    else scan_idx_next = '0;
    if (cmd.load_out) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pos       <= '0;
      scan_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pos       <= pos_next;
      scan_idx  <= scan_idx_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[rtl/tffp_dp.sv]
// datapath: frame shift line, tag window compare, held words, result register
// depends on tffp_pkg
`timescale 1ns / 1ps

module tffp_dp #(
  parameter int LAST_POS = tffp_pkg::LAST_POS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tffp_pkg::cfg_t    cfg,
  input  tffp_pkg::cmd_t    cmd,
  output tffp_pkg::status_t status,
  input  logic [7:0]        rx_byte,
  output logic [31:0]       time_word,
  output logic [31:0]       left_count,
  output logic [31:0]       right_count,
  output logic [31:0]       middle_count
);
  import tffp_pkg::*;

  // frame_buf[k] holds frame position k once the frame is complete
  logic [7:0]  frame_buf [LAST_POS+1];
  logic [7:0]  prev_byte;
  logic [7:0]  top_byte;
  logic [31:0] held_time, held_left, held_right, held_middle;
  logic [31:0] win_word;
  logic        sep_hit;

  // status compares
  assign status.start_hit = (rx_byte == cfg.start_char) && (prev_byte == cfg.header_char);
  assign status.end_hit   = (rx_byte == cfg.end_char);
  assign status.stop_hit  = (frame_buf[0] == CR_CHAR) && (frame_buf[1] == LF_CHAR);

  // scan window at the low end of the line
  assign sep_hit  = (frame_buf[5] == SEP_CHAR);
  assign win_word = {frame_buf[1], frame_buf[2], frame_buf[3], frame_buf[4]};

  // bytes past the frame read as zero during the scan
  assign top_byte = cmd.scan_step ? 8'd0 : rx_byte;

  // shift line
  always_ff @(posedge clk) begin
    if (cmd.start_frame) begin
      for (int k = 0; k < LAST_POS - 1; k++) frame_buf[k] <= frame_buf[k+2];
      frame_buf[LAST_POS-1] <= cfg.header_char;
      frame_buf[LAST_POS]   <= cfg.start_char;
    end else if (cmd.shift_in || cmd.scan_step) begin
      for (int k = 0; k < LAST_POS; k++) frame_buf[k] <= frame_buf[k+1];
      frame_buf[LAST_POS] <= top_byte;
    end
  end

  // previous byte and held words
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte   <= 8'd0;
      held_time   <= 32'd0;
      held_left   <= 32'd0;
      held_right  <= 32'd0;
      held_middle <= 32'd0;
    end else begin
      if (cmd.accept) prev_byte <= rx_byte;
      if (cmd.scan_step && sep_hit) begin
        if (frame_buf[0] == cfg.start_char) held_time   <= win_word;
        if (frame_buf[0] == cfg.left_tag)   held_left   <= win_word;
        if (frame_buf[0] == cfg.right_tag)  held_right  <= win_word;
        if (frame_buf[0] == cfg.middle_tag) held_middle <= win_word;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      time_word    <= held_time;
      left_count   <= held_left;
      right_count  <= held_right;
      middle_count <= held_middle;
    end
  end

endmodule

[rtl/tagged_feedback_frame_parser_core.sv]
// Frame parser top: one byte per cycle while input is not stalled; a frame is LAST_POS+1 bytes.
// After the end byte is taken the scan shifts the line one position a cycle, stopping at a CR LF
// pair or at the last position, then the result register is loaded once the output slot is free.
// Input is stalled during the scan, while the result is loaded and while it waits for a free output slot.
// Reset is synchronous: registers to their defaults, held words to zero, no frame open.
// depends on tffp_pkg, tffp_regs, tffp_ctrl, tffp_dp and the macros header
`timescale 1ns / 1ps
`include "tagged_feedback_frame_parser_core_macros.svh"

module tagged_feedback_frame_parser_core #(
  parameter int LAST_POS = tffp_pkg::LAST_POS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tffp_pkg::ADDR_W-1:0] paddr,
  input  logic [tffp_pkg::DATA_W-1:0] pwdata,
  output logic [tffp_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  rx_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 time_word,
  output logic [31:0]                 left_count,
  output logic [31:0]                 right_count,
  output logic [31:0]                 middle_count
);
  import tffp_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  // configuration registers
  tffp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // controller
  tffp_ctrl #(.LAST_POS(LAST_POS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  tffp_dp #(.LAST_POS(LAST_POS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .status       (status),
    .rx_byte      (rx_byte),
    .time_word    (time_word),
    .left_count   (left_count),
    .right_count  (right_count),
    .middle_count (middle_count)
  );

  // scan never overlaps an accepted input byte: input is stalled during the scan
  `TFFP_ASSERT_IMPLY(a_scan_blocks_input, cmd.scan_step, in_stall && !cmd.accept, "input taken during scan")
  // result register loads only into a free slot
  `TFFP_ASSERT_IMPLY(a_load_slot_free, cmd.load_out, !out_valid || !out_stall, "result overwritten")
  // shift line has at most one driver a cycle
  `TFFP_ASSERT_NEVER(a_one_shift, !$onehot0({cmd.start_frame, cmd.shift_in, cmd.scan_step}), "shift line conflict")

endmodule
